// ----- rtl/tetb_pkg.sv -----
`default_nettype none

package tetb_pkg;

  // Size of the timer bank and the widths that follow from it.
  localparam int unsigned MaxEvents = 16;
  localparam int unsigned SlotW     = $clog2(MaxEvents);
  localparam int unsigned CountW    = $clog2(MaxEvents + 1);

  // Request mode as it arrives on the input channel.
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // Kind code of a result.
  typedef enum logic [1:0] {
    KIND_ADD_ACK    = 2'd0,
    KIND_REMOVE_ACK = 2'd1,
    KIND_FIRED      = 2'd2,
    KIND_TICK_DONE  = 2'd3
  } kind_e;

  // Operation held in the command queue.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // One classified command.
  typedef struct packed {
    op_e         op;
    logic [31:0] period;
    logic        one_shot;
    logic        has_handler;
    logic [31:0] event_id;
  } cmd_t;

  // Write side of the command queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  // Read side of the command queue.
  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_rd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_SWEEP,
    BK_RESP
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/tetb_in_if.sv -----
`default_nettype none

// Request channel: one timer command per handshake.
interface tetb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] period;
  logic        one_shot;
  logic        has_handler;
  logic [31:0] event_id;

  modport source (
    output valid, mode, period, one_shot, has_handler, event_id,
    input  ready
  );

  modport sink (
    input  valid, mode, period, one_shot, has_handler, event_id,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tetb_out_if.sv -----
`default_nettype none

// Result channel: acks, firings and tick completions.
interface tetb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] result_id;
  logic        ok;
  logic [31:0] frame;
  logic [4:0]  active_count;
  logic        last;

  modport source (
    output valid, kind, result_id, ok, frame, active_count, last,
    input  ready
  );

  modport sink (
    input  valid, kind, result_id, ok, frame, active_count, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tetb_front.sv -----
`default_nettype none

module tetb_front (
  tetb_in_if.sink          req_i,
  input  logic             q_full_i,
  output tetb_pkg::q_wr_t  q_wr_o
);
  import tetb_pkg::*;

  logic accept;

  // A request is taken whenever the queue has room.
  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && !q_full_i;

  // Classify the request; the unused mode is consumed and dropped.
  always_comb begin
    q_wr_o.push             = 1'b0;
    q_wr_o.cmd.op           = OP_TICK;
    q_wr_o.cmd.period       = req_i.period;
    q_wr_o.cmd.one_shot     = req_i.one_shot;
    q_wr_o.cmd.has_handler  = req_i.has_handler;
    q_wr_o.cmd.event_id     = req_i.event_id;
    case (mode_e'(req_i.mode))
      MODE_TICK: begin
        q_wr_o.push   = accept;
        q_wr_o.cmd.op = OP_TICK;
      end
      MODE_ADD: begin
        q_wr_o.push   = accept;
        q_wr_o.cmd.op = OP_ADD;
      end
      MODE_REMOVE: begin
        q_wr_o.push   = accept;
        q_wr_o.cmd.op = OP_REMOVE;
      end
      default: begin
        q_wr_o.push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tetb_queue.sv -----
`default_nettype none

module tetb_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tetb_pkg::q_wr_t  q_wr_i,
  output logic             full_o,
  input  logic             pop_i,
  output tetb_pkg::q_rd_t  q_rd_o
);
  import tetb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o        = (cnt_q == CntW'(Depth));
  assign q_rd_o.empty  = (cnt_q == '0);
  assign q_rd_o.head   = mem_q[rd_ptr_q];
  assign do_push       = q_wr_i.push && !full_o;
  assign do_pop        = pop_i && !q_rd_o.empty;

  // Pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tetb_back.sv -----
`default_nettype none

module tetb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tetb_pkg::q_rd_t  q_rd_i,
  output logic             q_pop_o,
  tetb_out_if.source       rsp_o
);
  import tetb_pkg::*;

  // Slot state.
  logic [MaxEvents-1:0] valid_q, pending_q, visited_q;
  logic [31:0]          ident_q  [MaxEvents];
  logic [31:0]          period_q [MaxEvents];
  logic [31:0]          count_q  [MaxEvents];
  logic [MaxEvents-1:0] one_shot_q, handler_q;
  // less_q[j][i] is set when the id of slot j is below the id of slot i.
  logic [MaxEvents-1:0] less_q   [MaxEvents];
  logic [MaxEvents-1:0] less_col [MaxEvents];
  logic [31:0]          frame_q, idc_q;

  back_state_e state_q, state_d;

  // Staged acknowledge and output register.
  kind_e       ack_kind_q;
  logic [31:0] ack_id_q;
  logic        ack_ok_q;
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [31:0] out_id_q;
  logic        out_ok_q;
  logic [31:0] out_frame_q;
  logic [CountW-1:0] out_active_q;
  logic        out_last_q;

  // Control strobes from the sequencer.
  logic do_add, do_remove, do_tick, do_step, do_sweep, load_out;
  kind_e       load_kind;
  logic [31:0] load_id;
  logic        load_ok, load_last;

  // Lookup results.
  cmd_t                 head;
  logic [31:0]          nid, key;
  logic [MaxEvents-1:0] eq, lt, gt, hit;
  logic                 hit_any, free_any, add_ok;
  logic [SlotW-1:0]     hit_idx, free_idx, add_slot;

  // Walk results.
  logic [MaxEvents-1:0] cand, pick;
  logic [31:0]          sel_count, sel_period, sel_ident, inc;
  logic                 sel_handler, sel_one_shot, expired, fire, out_free;

  function automatic logic [CountW-1:0] pop_count(input logic [MaxEvents-1:0] v);
    logic [CountW-1:0] n;
    n = '0;
    for (int i = 0; i < MaxEvents; i++) begin
      n = n + CountW'(v[i]);
    end
    return n;
  endfunction

  assign head     = q_rd_i.head;
  assign nid      = idc_q + 32'd1;
  assign key      = (head.op == OP_ADD) ? nid : head.event_id;
  assign out_free = !out_valid_q || rsp_o.ready;

  // Compare every slot id with the lookup key and the new id.
  always_comb begin
    for (int i = 0; i < MaxEvents; i++) begin
      eq[i] = (ident_q[i] == key);
      lt[i] = (ident_q[i] < nid);
      gt[i] = !lt[i] && !eq[i];
    end
  end

  assign hit      = valid_q & eq;
  assign hit_any  = |hit;
  assign free_any = ~&valid_q;
  assign add_ok   = hit_any || free_any;
  assign add_slot = hit_any ? hit_idx : free_idx;

  // Encode the matching slot and the lowest free slot.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = MaxEvents - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  // The next slot in id order is the unvisited one no other unvisited slot undercuts.
  assign cand = valid_q & ~visited_q;

  always_comb begin
    for (int i = 0; i < MaxEvents; i++) begin
      for (int j = 0; j < MaxEvents; j++) begin
        less_col[i][j] = less_q[j][i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxEvents; i++) begin
      pick[i] = cand[i] && !(|(cand & less_col[i]));
    end
  end

  // Read the picked slot.
  always_comb begin
    sel_count    = '0;
    sel_period   = '0;
    sel_ident    = '0;
    sel_handler  = 1'b0;
    sel_one_shot = 1'b0;
    for (int i = 0; i < MaxEvents; i++) begin
      if (pick[i]) begin
        sel_count    = sel_count | count_q[i];
        sel_period   = sel_period | period_q[i];
        sel_ident    = sel_ident | ident_q[i];
        sel_handler  = sel_handler | handler_q[i];
        sel_one_shot = sel_one_shot | one_shot_q[i];
      end
    end
  end

  assign inc     = sel_count + 32'd1;
  assign expired = (inc >= sel_period);
  assign fire    = expired && sel_handler;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    do_add    = 1'b0;
    do_remove = 1'b0;
    do_tick   = 1'b0;
    do_step   = 1'b0;
    do_sweep  = 1'b0;
    load_out  = 1'b0;
    load_kind = ack_kind_q;
    load_id   = ack_id_q;
    load_ok   = ack_ok_q;
    load_last = 1'b1;
    case (state_q)
      BK_IDLE: begin
        if (!q_rd_i.empty) begin
          q_pop_o = 1'b1;
          case (head.op)
            OP_ADD: begin
              do_add  = 1'b1;
              state_d = BK_RESP;
            end
            OP_REMOVE: begin
              do_remove = 1'b1;
              state_d   = BK_RESP;
            end
            OP_TICK: begin
              do_tick = 1'b1;
              state_d = BK_WALK;
            end
            default: begin
              state_d = BK_IDLE;
            end
          endcase
        end
      end
      BK_WALK: begin
        load_kind = KIND_FIRED;
        load_id   = sel_ident;
        load_ok   = 1'b0;
        load_last = 1'b0;
        if (cand == '0) begin
          state_d = BK_SWEEP;
        end else if (!fire || out_free) begin
          do_step  = 1'b1;
          load_out = fire;
        end
      end
      BK_SWEEP: begin
        do_sweep = 1'b1;
        state_d  = BK_RESP;
      end
      BK_RESP: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Slot control state, counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pending_q   <= '0;
      visited_q   <= '0;
      frame_q     <= '0;
      idc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (do_add && add_ok) begin
        idc_q             <= nid;
        valid_q[add_slot] <= 1'b1;
        if (!hit_any) begin
          pending_q[add_slot] <= 1'b0;
        end
      end
      if (do_remove) begin
        pending_q <= pending_q | hit;
      end
      if (do_tick) begin
        frame_q   <= frame_q + 32'd1;
        visited_q <= '0;
      end
      if (do_step) begin
        visited_q <= visited_q | pick;
        if (expired && (!sel_handler || sel_one_shot)) begin
          pending_q <= pending_q | pick;
        end
      end
      if (do_sweep) begin
        valid_q   <= valid_q & ~pending_q;
        pending_q <= '0;
      end
    end
  end

  // Slot contents, id order, staged acknowledge and output payload.
  always_ff @(posedge clk_i) begin
    if (do_add && add_ok) begin
      ident_q[add_slot]    <= nid;
      period_q[add_slot]   <= head.period;
      count_q[add_slot]    <= '0;
      one_shot_q[add_slot] <= head.one_shot;
      handler_q[add_slot]  <= head.has_handler;
      for (int j = 0; j < MaxEvents; j++) begin
        if (SlotW'(j) == add_slot) begin
          less_q[add_slot][j] <= 1'b0;
        end else begin
          less_q[add_slot][j] <= gt[j];
          less_q[j][add_slot] <= lt[j];
        end
      end
    end
    if (do_step) begin
      for (int i = 0; i < MaxEvents; i++) begin
        if (pick[i]) begin
          count_q[i] <= fire ? 32'd0 : inc;
        end
      end
    end
    if (do_add) begin
      ack_kind_q <= KIND_ADD_ACK;
      ack_id_q   <= add_ok ? nid : 32'd0;
      ack_ok_q   <= add_ok;
    end
    if (do_remove) begin
      ack_kind_q <= KIND_REMOVE_ACK;
      ack_id_q   <= 32'd0;
      ack_ok_q   <= hit_any;
    end
    if (do_sweep) begin
      ack_kind_q <= KIND_TICK_DONE;
      ack_id_q   <= 32'd0;
      ack_ok_q   <= 1'b0;
    end
    if (load_out) begin
      out_kind_q   <= load_kind;
      out_id_q     <= load_id;
      out_ok_q     <= load_ok;
      out_last_q   <= load_last;
      out_frame_q  <= frame_q;
      out_active_q <= pop_count(valid_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.kind         = out_kind_q;
  assign rsp_o.result_id    = out_id_q;
  assign rsp_o.ok           = out_ok_q;
  assign rsp_o.frame        = out_frame_q;
  assign rsp_o.active_count = out_active_q;
  assign rsp_o.last         = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/tick_event_timer_bank_top.sv -----
// Bank of sixteen tick-driven event timers.
// Requests arrive on req_i (valid/ready): mode 0 ticks, mode 1 adds an event
// with a period and one-shot and handler flags, mode 2 removes an event by id.
// Mode 3 requests are taken and ignored. Results leave on rsp_o (valid/ready):
// one ack per add or remove; per tick, one fired result per expiring event
// with a handler, in ascending id order, then a tick-done result with last set.
// The front classifies requests into a command queue of QueueDepth entries;
// the back sequencer executes one command at a time.
// A tick walks one occupied slot per cycle while no firing is held back by
// a busy output register. An add or remove is acked before the back takes
// its next command.
// A stalled receiver holds the output register; the walk pauses on a firing
// until the register frees, and the front keeps taking requests until the
// queue fills. Reset empties every slot and clears the frame and id counters.
`default_nettype none

module tick_event_timer_bank_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tetb_in_if.sink     req_i,
  tetb_out_if.source  rsp_o
);
  import tetb_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Request classification.
  tetb_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  // Command queue between front and back.
  tetb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  // Timer slots and result sequencing.
  tetb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_rd_i  (q_rd),
    .q_pop_o (q_pop),
    .rsp_o   (rsp_o)
  );

`ifndef SYNTH
  // The front never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_wr.push |-> !q_full)
    else $error("command pushed into a full queue");

  // The back only pops a queue that holds a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_rd.empty)
    else $error("command popped from an empty queue");

  // An ignored mode never reaches the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (req_i.valid && req_i.ready && (req_i.mode == MODE_NONE)) |-> !q_wr.push)
    else $error("ignored request was queued");

  // Only firings are followed by further results of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (rsp_o.valid && !rsp_o.last) |-> (rsp_o.kind == KIND_FIRED))
    else $error("non-final result that is not a firing");
`endif

endmodule

`default_nettype wire
